### hdl/axis_jitter_deadzone_calibrator_top_macros.svh
// Assertion macros shared by the axis jitter / dead-zone calibrator RTL.
// Expects clk_i and rst_ni in the scope that uses them; no other dependencies.
`ifndef AXIS_JITTER_DEADZONE_CALIBRATOR_TOP_MACROS_SVH
`define AXIS_JITTER_DEADZONE_CALIBRATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside of reset.
`define AJDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside of reset.
`define AJDC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define AJDC_ASSERT(lbl, prop, msg)
`define AJDC_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### hdl/ajdc_pkg.sv
// Package for the axis jitter / dead-zone calibrator: constants, register
// codes and the request/response types of the divider. No dependencies.
`default_nettype none

package ajdc_pkg;

  // Repeat counter saturates here, and a sample inside the jitter band is
  // released once the count reaches it.
  localparam logic [1:0]  REPEAT_LIMIT = 2'd3;
  localparam logic [1:0]  REPEAT_SAT   = 2'd3;
  localparam logic [15:0] PREV_RESET   = 16'd200;

  // Output saturation bound for the calibrated value.
  localparam int unsigned OUT_MAX = 20000;

  // Divider: magnitude of the scaled product and of the divisor.
  localparam int unsigned DIV_W  = 31;
  localparam int unsigned DEN_W  = 16;
  localparam int unsigned DCNT_W = $clog2(DIV_W);

  // Register index codes (byte address / 4).
  typedef enum logic [2:0] {
    REG_JITTER_MARGIN = 3'd0,
    REG_DEAD_ZONE     = 3'd1,
    REG_LOW_LIMIT     = 3'd2,
    REG_CENTER_POINT  = 3'd3,
    REG_HIGH_LIMIT    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### hdl/ajdc_div.sv
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on ajdc_pkg for widths and the request/response structs.
`default_nettype none

module ajdc_div
  import ajdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_diff;
  logic              fits;

  // The dividend shifts out of the top of quo_q while quotient bits enter
  // at the bottom.
  assign trial      = {rem_q, quo_q[DIV_W-1]};
  assign trial_diff = trial - {1'b0, den_q};
  assign fits       = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

### hdl/axis_jitter_deadzone_calibrator_top.sv
// Joystick axis anti-jitter, dead-zone and calibration stage (one axis).
// Depends on ajdc_pkg, ajdc_div and the assertion macro header.
//
// One raw sample enters per item on the slave stream; one result leaves on
// the master stream with the calibrated value in bits 15:0 and the filtered
// sample in bits 31:16. The block works on one item at a time and deasserts
// s_axis_tready_o from acceptance until the result is placed in the output
// register. An item goes straight to the output when the value falls in the
// dead zone or needs no scaling. When the longer side of the travel must be
// scaled to the shorter one, the item also goes through a signed multiply and
// the radix-2 divider, which produces one quotient bit per cycle over a
// 31-bit magnitude; for such items the divider sets the rate. The output
// register lets the next item be accepted while a result still waits to be
// taken. Configuration is to be written by the user over the APB-style port
// at byte address 4*index while the block is idle; the block itself does not
// enforce this. All registers reset to zero and have no side effects on read.
`default_nettype none
`include "axis_jitter_deadzone_calibrator_top_macros.svh"

module axis_jitter_deadzone_calibrator_top
  import ajdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: tdata = raw_sample[15:0].
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  // Output stream: tdata = calibrated_value[15:0], filtered_sample[31:16].
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  // Configuration port.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOLD,
    ST_CAL,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_e;

  // Configuration registers.
  logic [7:0]  jitter_q;
  logic [7:0]  dz_q;
  logic [14:0] lo_q;
  logic [14:0] center_q;
  logic [14:0] hi_q;
  cfg_reg_e    reg_idx;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign reg_idx  = cfg_reg_e'(paddr_i[4:2]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jitter_q <= '0;
      dz_q     <= '0;
      lo_q     <= '0;
      center_q <= '0;
      hi_q     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_JITTER_MARGIN: jitter_q <= pwdata_i[7:0];
        REG_DEAD_ZONE:     dz_q     <= pwdata_i[7:0];
        REG_LOW_LIMIT:     lo_q     <= pwdata_i[14:0];
        REG_CENTER_POINT:  center_q <= pwdata_i[14:0];
        REG_HIGH_LIMIT:    hi_q     <= pwdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_JITTER_MARGIN: prdata_o = {24'd0, jitter_q};
      REG_DEAD_ZONE:     prdata_o = {24'd0, dz_q};
      REG_LOW_LIMIT:     prdata_o = {17'd0, lo_q};
      REG_CENTER_POINT:  prdata_o = {17'd0, center_q};
      REG_HIGH_LIMIT:    prdata_o = {17'd0, hi_q};
      default:           prdata_o = '0;
    endcase
  end

  // Sequencer state and per-item registers.
  state_e             state_q;
  logic [15:0]        sample_q;
  logic [15:0]        prev_q;
  logic [1:0]         count_q;
  logic [15:0]        held_q;
  logic [15:0]        v_q;
  logic [15:0]        filt_q;
  logic signed [17:0] diff_q;
  logic signed [17:0] numw_q;
  logic signed [17:0] den_q;
  logic signed [31:0] prod_q;
  logic               neg_q;
  logic [15:0]        cal_q;
  logic               m_valid_q;
  logic [31:0]        m_data_q;

  // Repeat tracking and jitter hold on the stored sample.
  logic [1:0]         count_new;
  logic signed [17:0] s_s, h_s, m_s;
  logic               out_band;

  assign count_new = (sample_q == prev_q) ?
                     ((count_q < REPEAT_SAT) ? count_q + 2'd1 : count_q) : 2'd0;
  assign s_s       = $signed({2'b00, sample_q});
  assign h_s       = $signed({2'b00, held_q});
  assign m_s       = $signed({10'd0, jitter_q});
  assign out_band  = (s_s > h_s) ? (s_s > h_s + m_s) : (s_s < h_s - m_s);

  // Dead zone, clamping and scale selection on the held value.
  logic signed [17:0] v_s, c_s, lo_s, hi_s, n_s;
  logic signed [17:0] edge_lo, edge_hi, w1, w2, vc_s, diff;
  logic [15:0]        vc;
  logic               in_dz, below, need_scale;
  logic signed [17:0] numw, den;
  logic signed [15:0] diff_sat;

  assign v_s     = $signed({2'b00, v_q});
  assign c_s     = $signed({3'b000, center_q});
  assign lo_s    = $signed({3'b000, lo_q});
  assign hi_s    = $signed({3'b000, hi_q});
  assign n_s     = $signed({10'd0, dz_q});
  assign edge_lo = c_s - n_s;
  assign edge_hi = c_s + n_s;
  assign in_dz   = (v_s >= edge_lo) && (v_s <= edge_hi);

  // A value below the low limit wins over the high test when limits cross.
  always_comb begin
    priority if (v_s < lo_s) begin
      vc = {1'b0, lo_q};
    end else if (v_s > hi_s) begin
      vc = {1'b0, hi_q};
    end else begin
      vc = v_q;
    end
  end

  assign vc_s       = $signed({2'b00, vc});
  assign w1         = edge_lo - lo_s;
  assign w2         = hi_s - edge_hi;
  assign below      = vc_s < c_s;
  assign diff       = below ? (vc_s - edge_lo) : (vc_s - edge_hi);
  assign need_scale = below ? (w1 > w2) : (w2 > w1);
  assign numw       = below ? w2 : w1;
  assign den        = below ? w1 : w2;

  always_comb begin
    if (diff > 18'sd20000) begin
      diff_sat = 16'sd20000;
    end else if (diff < -18'sd20000) begin
      diff_sat = -16'sd20000;
    end else begin
      diff_sat = diff[15:0];
    end
  end

  // Multiply, magnitudes for the divider, and the signed quotient.
  logic signed [35:0] prod_full;
  logic [31:0]        prod_mag;
  logic [17:0]        den_mag;
  logic [15:0]        q_sat;
  logic [15:0]        q_signed;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign prod_full = diff_q * numw_q;
  assign prod_mag  = prod_q[31] ? 32'(-prod_q) : 32'(prod_q);
  assign den_mag   = den_q[17] ? 18'(-den_q) : 18'(den_q);
  assign q_sat     = (div_rsp.quotient > DIV_W'(OUT_MAX)) ?
                     16'(OUT_MAX) : div_rsp.quotient[15:0];
  assign q_signed  = neg_q ? (16'd0 - q_sat) : q_sat;

  assign div_req.start    = (state_q == ST_START);
  assign div_req.dividend = prod_mag[DIV_W-1:0];
  assign div_req.divisor  = den_mag[DEN_W-1:0];

  ajdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic out_load;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      prev_q    <= PREV_RESET;
      count_q   <= '0;
      held_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          prev_q <= sample_q;
          if (out_band) begin
            count_q <= count_new;
            held_q  <= sample_q;
          end else if (count_new < REPEAT_LIMIT) begin
            count_q <= count_new;
          end else begin
            count_q <= '0;
            held_q  <= sample_q;
          end
          state_q <= ST_CAL;
        end
        ST_CAL: begin
          if (in_dz || !need_scale || (den == 18'sd0)) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:   state_q <= ST_START;
        ST_START: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      sample_q <= s_axis_tdata_i;
    end
    if (state_q == ST_HOLD) begin
      v_q <= (!out_band && (count_new < REPEAT_LIMIT)) ? held_q : sample_q;
    end
    if (state_q == ST_CAL) begin
      filt_q <= in_dz ? v_q : vc;
      diff_q <= diff;
      numw_q <= numw;
      den_q  <= den;
      if (in_dz || (need_scale && (den == 18'sd0))) begin
        cal_q <= '0;
      end else begin
        cal_q <= diff_sat;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_full[31:0];
    end
    if (state_q == ST_START) begin
      neg_q <= prod_q[31] ^ den_q[17];
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      cal_q <= q_signed;
    end
    if (out_load) begin
      m_data_q <= {filt_q, cal_q};
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // The divider only runs while an item is in flight.
  `AJDC_ASSERT_NEVER(a_div_busy_ready, div_rsp.busy && s_axis_tready_o,
                     "divider busy while accepting items")
  // An accepted item closes the input right after it is taken.
  `AJDC_ASSERT(a_one_item, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o,
               "input accepted twice in a row")
  // The calibrated value stays inside its saturation bounds.
  `AJDC_ASSERT(a_cal_range,
               m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[15:0]) <= 16'sd20000 &&
                                    $signed(m_axis_tdata_o[15:0]) >= -16'sd20000),
               "calibrated value out of range")

endmodule

`default_nettype wire
